// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cdsd_pkg.sv =====
package cdsd_pkg;

	// Field and intermediate widths
	localparam int TIME_W = 32;
	localparam int MIN_W = 27;   // seconds / 60 fits in 27 bits
	localparam int HR_W = 21;    // minutes / 60 fits in 21 bits
	localparam int DAY_W = 16;   // hours / 24 fits in 16 bits
	localparam int SEG_W = 8;
	localparam int PAIR_W = 7;   // a two-digit group, 0..99

	// Divisors of the time split
	localparam int SEC_DIV = 60;
	localparam int MIN_DIV = 60;
	localparam int HR_DIV = 24;

	// Remainder bits collected along the divider row: seconds, minutes, hours
	localparam int SEC_RW = $clog2(SEC_DIV);
	localparam int MIN_RW = $clog2(MIN_DIV);
	localparam int HR_RW = $clog2(HR_DIV);
	localparam int SIDE_W = SEC_RW + MIN_RW + HR_RW;

	localparam logic [PAIR_W-1:0] DAYS_MAX = PAIR_W'(99);
	localparam logic [TIME_W-1:0] TARGET_RESET = 32'd1635231600;

	localparam int FRAME_LEN = 8;
	localparam int CNT_W = $clog2(FRAME_LEN);

	// Segment bits
	localparam logic [SEG_W-1:0] SEG_A = 8'h01;
	localparam logic [SEG_W-1:0] SEG_F = 8'h02;
	localparam logic [SEG_W-1:0] SEG_G = 8'h04;
	localparam logic [SEG_W-1:0] SEG_E = 8'h08;
	localparam logic [SEG_W-1:0] SEG_D = 8'h10;
	localparam logic [SEG_W-1:0] SEG_C = 8'h20;
	localparam logic [SEG_W-1:0] SEG_B = 8'h40;
	localparam logic [SEG_W-1:0] SEG_DP = 8'h80;

	typedef logic [SEG_W-1:0] seg_t;
	typedef seg_t [FRAME_LEN-1:0] frame_t;

	// Segment pattern of one decimal digit
	function automatic seg_t digit_seg(input logic [3:0] d);
		seg_t s;
		unique case (d)
			4'd0: s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
			4'd1: s = SEG_B | SEG_C;
			4'd2: s = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
			4'd3: s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
			4'd4: s = SEG_F | SEG_G | SEG_B | SEG_C;
			4'd5: s = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
			4'd6: s = SEG_A | SEG_F | SEG_G | SEG_E | SEG_C | SEG_D;
			4'd7: s = SEG_A | SEG_B | SEG_C;
			4'd8: s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
			4'd9: s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
			default: s = '0;
		endcase
		return s;
	endfunction

	// Tens digit of a value below 100: multiply by 205/2048
	function automatic logic [3:0] tens_of(input logic [PAIR_W-1:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

	function automatic logic [3:0] units_of(input logic [PAIR_W-1:0] v);
		logic [PAIR_W-1:0] t10;
		t10 = PAIR_W'(tens_of(v)) * PAIR_W'(10);
		return 4'(v - t10);
	endfunction

endpackage

// ===== hw/rtl/cdsd_in_if.sv =====
interface cdsd_in_if import cdsd_pkg::*; ();
	logic valid;
	logic ready;
	logic [TIME_W-1:0] now_time;

	modport source(output valid, output now_time, input ready);
	modport sink(input valid, input now_time, output ready);
endinterface

// ===== hw/rtl/cdsd_out_if.sv =====
interface cdsd_out_if import cdsd_pkg::*; ();
	logic valid;
	logic ready;
	logic [SEG_W-1:0] segment_byte;
	logic latch;

	modport source(output valid, output segment_byte, output latch, input ready);
	modport sink(input valid, input segment_byte, input latch, output ready);
endinterface

// ===== hw/rtl/cdsd_div_cell.sv =====
`include "assert_macros.svh"

// One divider cell: quotient by a constant through a reciprocal multiply,
// then a single correction step. The remainder is shifted into the side word.
module cdsd_div_cell import cdsd_pkg::*; #(
	parameter int XW = 32,
	parameter int DIVISOR = 60
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [XW-1:0]     in_x,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_v,
	output logic [XW-1:0]     out_q,
	output logic [SIDE_W-1:0] out_side
);
	localparam int RW = $clog2(DIVISOR);
	localparam logic [2*XW-1:0] SCALE = (2*XW)'(1) << XW;
	localparam logic [2*XW-1:0] RECIP_FULL = SCALE / DIVISOR;
	localparam logic [XW-1:0] RECIP = RECIP_FULL[XW-1:0];
	localparam logic [XW-1:0] DIV_X = XW'(DIVISOR);

	logic [2*XW-1:0] prod;
	logic            v_s1;
	logic [XW-1:0]   x_s1;
	logic [XW-1:0]   qe_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [XW-1:0]   r_full;
	logic            fix;
	logic [XW-1:0]   q_fix;
	logic [XW-1:0]   r_fix;
	logic            v_s2;
	logic [XW-1:0]   q_s2;
	logic [RW-1:0]   r_s2;
	logic [SIDE_W-1:0] side_s2;

	// Estimate the quotient; it is the true one or one short
	assign prod = {{XW{1'b0}}, in_x} * {{XW{1'b0}}, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= in_x;
			qe_s1 <= prod[2*XW-1:XW];
			side_s1 <= in_side;
		end
	end

	// Correct the estimate once
	always_comb begin
		r_full = x_s1 - qe_s1 * DIV_X;
		fix = (r_full >= DIV_X);
		q_fix = qe_s1 + XW'(fix);
		r_fix = fix ? (r_full - DIV_X) : r_full;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2 <= q_fix;
			r_s2 <= r_fix[RW-1:0];
			side_s2 <= {side_s1[SIDE_W-RW-1:0], r_fix[RW-1:0]};
		end
	end

	assign out_v = v_s2;
	assign out_q = q_s2;
	assign out_side = side_s2;

	`ASSERT_IMPLIES(a_rem_range, v_s2, (XW'(r_s2) < DIV_X), "remainder not below divisor")
endmodule

// ===== hw/rtl/cdsd_encode.sv =====
// Saturate days, split the four groups into digits and map to segments.
module cdsd_encode import cdsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [DAY_W-1:0]  days,
	input  logic [SIDE_W-1:0] side,
	output logic              out_v,
	output frame_t            out_frame
);
	logic [PAIR_W-1:0] sec_v;
	logic [PAIR_W-1:0] min_v;
	logic [PAIR_W-1:0] hr_v;
	logic [PAIR_W-1:0] day_v;
	frame_t            frame_d;
	logic              v_s1;
	frame_t            frame_s1;

	// Unpack remainders: seconds shifted in first, hours last
	always_comb begin
		sec_v = PAIR_W'(side[SIDE_W-1 -: SEC_RW]);
		min_v = PAIR_W'(side[HR_RW +: MIN_RW]);
		hr_v = PAIR_W'(side[HR_RW-1:0]);
		day_v = (days > DAY_W'(DAYS_MAX)) ? DAYS_MAX : days[PAIR_W-1:0];
	end

	// Build the frame in shift order, units before tens
	always_comb begin
		frame_d[0] = digit_seg(units_of(sec_v));
		frame_d[1] = digit_seg(tens_of(sec_v));
		frame_d[2] = digit_seg(units_of(min_v)) | SEG_DP;
		frame_d[3] = digit_seg(tens_of(min_v));
		frame_d[4] = digit_seg(units_of(hr_v)) | SEG_DP;
		frame_d[5] = digit_seg(tens_of(hr_v));
		frame_d[6] = digit_seg(units_of(day_v)) | SEG_DP;
		frame_d[7] = digit_seg(tens_of(day_v));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frame_s1 <= frame_d;
		end
	end

	assign out_v = v_s1;
	assign out_frame = frame_s1;
endmodule

// ===== hw/rtl/cdsd_serializer.sv =====
`include "assert_macros.svh"

// Shift one frame out, one byte per accepted item, latch on the last byte.
module cdsd_serializer import cdsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  frame_t            in_frame,
	output logic              load,
	cdsd_out_if.source        seg_ch
);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAME_LEN - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	frame_t           frame_q;

	// Take a new frame when empty or when the last byte leaves
	assign load = !busy_q || (seg_ch.ready && (cnt_q == LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= in_v;
			cnt_q <= '0;
		end else if (seg_ch.ready) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_v) begin
			frame_q <= in_frame;
		end
	end

	assign seg_ch.valid = busy_q;
	assign seg_ch.segment_byte = frame_q[cnt_q];
	assign seg_ch.latch = (cnt_q == LAST);

	`ASSERT_NEXT(a_drain_idle, (seg_ch.valid && seg_ch.ready && seg_ch.latch && !in_v), !seg_ch.valid, "output stays valid after last byte with no frame")
	`ASSERT_NEXT(a_new_frame_start, (load && in_v), (seg_ch.valid && (cnt_q == '0)), "frame did not start at first byte")
endmodule

// ===== hw/rtl/countdown_seven_segment_driver_core.sv =====
// An accepted item passes the input stage, the three divider cells and the encoder, each
// registered, before the byte serializer takes its frame of 8 bytes and sends it out; items
// are taken every cycle while the divider row has room, and a repeated reading
// produces no frame. Async reset (arst_n low) clears the pipeline, drops any
// frame in flight, sets the target to its default and the last reading to zero.
`include "assert_macros.svh"

module countdown_seven_segment_driver_core import cdsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [TIME_W-1:0] cfg_wr_data,
	cdsd_in_if.sink           now_ch,
	cdsd_out_if.source        seg_ch
);
	logic              adv;
	logic              acc;
	logic [TIME_W-1:0] target_q;
	logic [TIME_W-1:0] last_q;
	logic              v_s0;
	logic [TIME_W-1:0] left_s0;

	logic              sec_v;
	logic [TIME_W-1:0] sec_q;
	logic [SIDE_W-1:0] sec_side;
	logic              min_v;
	logic [MIN_W-1:0]  min_q;
	logic [SIDE_W-1:0] min_side;
	logic              hr_v;
	logic [HR_W-1:0]   hr_q;
	logic [SIDE_W-1:0] hr_side;
	logic              enc_v;
	frame_t            enc_frame;
	logic              ser_load;

	// Whole row advances unless a finished frame waits on the serializer
	assign adv = !enc_v || ser_load;
	assign now_ch.ready = adv;
	assign acc = now_ch.valid && adv;

	// Hold target and the last reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			last_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				target_q <= cfg_wr_data;
			end
			if (acc && (now_ch.now_time != last_q)) begin
				last_q <= now_ch.now_time;
			end
		end
	end

	// Drop repeats and form seconds left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (adv) begin
			v_s0 <= acc && (now_ch.now_time != last_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_s0 <= target_q - now_ch.now_time;
		end
	end

	cdsd_div_cell #(.XW(TIME_W), .DIVISOR(SEC_DIV)) u_cell_sec (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_v(v_s0), .in_x(left_s0), .in_side('0),
		.out_v(sec_v), .out_q(sec_q), .out_side(sec_side)
	);

	cdsd_div_cell #(.XW(MIN_W), .DIVISOR(MIN_DIV)) u_cell_min (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_v(sec_v), .in_x(sec_q[MIN_W-1:0]), .in_side(sec_side),
		.out_v(min_v), .out_q(min_q), .out_side(min_side)
	);

	cdsd_div_cell #(.XW(HR_W), .DIVISOR(HR_DIV)) u_cell_hr (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_v(min_v), .in_x(min_q[HR_W-1:0]), .in_side(min_side),
		.out_v(hr_v), .out_q(hr_q), .out_side(hr_side)
	);

	cdsd_encode u_encode (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_v(hr_v), .days(hr_q[DAY_W-1:0]), .side(hr_side),
		.out_v(enc_v), .out_frame(enc_frame)
	);

	cdsd_serializer u_serializer (
		.clk(clk), .arst_n(arst_n),
		.in_v(enc_v), .in_frame(enc_frame), .load(ser_load),
		.seg_ch(seg_ch)
	);

	`ASSERT_NEXT(a_repeat_dropped, (acc && (now_ch.now_time == last_q)), !v_s0, "repeated reading started a frame")
	`ASSERT_NEXT(a_stall_holds, (enc_v && !adv), enc_v, "waiting frame lost during stall")
endmodule
